// File: rtl/core/mrrf_pkg.sv
`default_nettype none

package mrrf_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned BodyBytes  = 6;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam int unsigned PaddrW     = 3;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [IdxW-1:0] IdxCrcFirst = IdxW'(BodyBytes);
  localparam logic [IdxW-1:0] IdxLast     = IdxW'(FrameBytes - 1);

  localparam logic RegCrcHighFirst = 1'b0;

  typedef logic [IdxW-1:0] idx_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/modbus_rtu_request_framer.sv
`default_nettype none

// Modbus RTU request framer. A request is taken when start is high and busy is
// low; the block then emits the eight frame bytes on consecutive cycles, one
// beat per cycle marked by frame_valid_o, the last beat flagged by frame_last_o.
// The receiver cannot stall the stream: every beat appears exactly once. busy
// drops during the final beat, so requests may follow back to back. The CRC-16
// is folded in one byte per cycle as the six body bytes go out, and its two
// bytes follow in the order chosen by crc_high_first (reset: low byte first).
// Register 0 (byte address 0) holds crc_high_first in bit 0.
module modbus_rtu_request_framer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire  [7:0]                       server_address_i,
  input  wire  [7:0]                       function_code_i,
  input  wire  [15:0]                      register_address_i,
  input  wire  [7:0]                       data_high_i,
  input  wire  [7:0]                       data_low_i,
  output logic                             frame_valid_o,
  output logic [7:0]                       frame_byte_o,
  output logic                             frame_last_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mrrf_pkg::PaddrW-1:0]      paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic                 accept;
  logic                 cfg_wr;
  logic                 reg_sel;
  logic                 crc_high_first_q;
  logic                 active_q, active_d;
  mrrf_pkg::idx_t       idx_q, idx_d;
  logic [15:0]          crc_q, crc_d;
  logic [7:0]           addr_q, func_q, regh_q, regl_q, dath_q, datl_q;
  logic [7:0]           body_byte;
  logic                 is_last;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[mrrf_pkg::PaddrW-1:2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {31'd0, crc_high_first_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_high_first_q <= 1'b0;
    end else if (cfg_wr) begin
      crc_high_first_q <= pwdata[0];
    end
  end

  assign is_last = (idx_q == mrrf_pkg::IdxLast);
  assign busy    = active_q && !is_last;
  assign accept  = start && !busy;

  always_comb begin
    case (idx_q)
      3'd0:    body_byte = addr_q;
      3'd1:    body_byte = func_q;
      3'd2:    body_byte = regh_q;
      3'd3:    body_byte = regl_q;
      3'd4:    body_byte = dath_q;
      3'd5:    body_byte = datl_q;
      default: body_byte = 8'h00;
    endcase
  end

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    if (accept) begin
      active_d = 1'b1;
      idx_d    = '0;
      crc_d    = mrrf_pkg::CrcInit;
    end else if (active_q) begin
      if (is_last) begin
        active_d = 1'b0;
      end
      idx_d = idx_q + 1'b1;
      if (idx_q < mrrf_pkg::IdxCrcFirst) begin
        crc_d = mrrf_pkg::crc_step(crc_q, body_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (accept) begin
      addr_q <= server_address_i;
      func_q <= function_code_i;
      regh_q <= register_address_i[15:8];
      regl_q <= register_address_i[7:0];
      dath_q <= data_high_i;
      datl_q <= data_low_i;
    end
  end

  always_comb begin
    frame_valid_o = active_q;
    frame_last_o  = active_q && is_last;
    if (idx_q < mrrf_pkg::IdxCrcFirst) begin
      frame_byte_o = body_byte;
    end else if ((idx_q == mrrf_pkg::IdxCrcFirst) != crc_high_first_q) begin
      frame_byte_o = crc_q[7:0];
    end else begin
      frame_byte_o = crc_q[15:8];
    end
  end

`ifndef SYNTHESIS
  a_last_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |-> frame_valid_o)
    else $error("last flag outside a frame");

  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> frame_valid_o && !frame_last_o && (idx_q == '0))
    else $error("accepted request did not start a frame");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && !frame_last_o) |=> frame_valid_o)
    else $error("gap inside a frame");

  a_busy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> frame_valid_o && !frame_last_o)
    else $error("busy without a frame in flight");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_last_o && !accept) |=> !frame_valid_o)
    else $error("beats continue after the last beat");
`endif

endmodule

`default_nettype wire
